FILE: design/dlts_pkg.sv
// Package for the delta-list timer queue: sizes, status and operation codes,
// and the controller-to-datapath command and status structs. No dependencies.
package dlts_pkg;

    localparam int Slots   = 16;
    localparam int MaxPops = 16;
    localparam int IdxW    = $clog2(Slots);
    localparam int CntW    = $clog2(Slots + 1);

    localparam logic [1:0] FUNC_ADD      = 2'd0;
    localparam logic [1:0] FUNC_TICK     = 2'd1;
    localparam logic [1:0] FUNC_DISPATCH = 2'd2;
    localparam logic [1:0] FUNC_DELETE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_BADSLOT = 3'd2;
    localparam logic [2:0] ST_RAN     = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    typedef struct packed {
        logic load;       // capture the slot index of the input word
        logic ins_init;   // begin an insert walk
        logic ins_step;   // one walk step
        logic ins_write;  // shift and place the new entry
        logic rem_write;  // shift out slot at rem index
        logic rem_head;   // remove uses index 0 and latches head for reinsertion
        logic tick;
        logic use_head;   // insert from latched head instead of input
    } t_dp_cmd;

    typedef struct packed {
        logic           full;
        logic           empty;
        logic           head_zero;
        logic           bad_slot;
        logic           walk_done;
        logic           head_periodic;
        logic [7:0]     head_handle;
        logic [CntW-1:0] count;
    } t_dp_sts;

endpackage

FILE: design/dlts_datapath.sv
// Datapath of the delta-list timer queue: entry registers, the insert walk
// and the shift logic for insert and remove. Uses dlts_pkg.
module dlts_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlts_pkg::t_dp_cmd             i_cmd,
    input  logic [7:0]                    i_task_handle,
    input  logic [31:0]                   i_start_delay,
    input  logic [31:0]                   i_repeat_period,
    input  logic [3:0]                    i_slot,
    output dlts_pkg::t_dp_sts             o_sts
);
    localparam int S = dlts_pkg::Slots;
    localparam int IW = dlts_pkg::IdxW;
    localparam int CW = dlts_pkg::CntW;

    logic [31:0] r_delta  [S];
    logic [31:0] r_period [S];
    logic [7:0]  r_handle [S];
    logic [CW-1:0] r_count;

    // insert working registers
    logic [31:0] r_ins_d, r_ins_p;
    logic [7:0]  r_ins_h;
    logic [CW-1:0] r_pos;
    logic [3:0]  r_slot;
    // head popped by a dispatch
    logic [31:0] r_hd_p;
    logic [7:0]  r_hd_h;

    logic [IW-1:0] pos_idx;
    logic [31:0]   walk_delta;
    logic          walk_more;
    logic [CW-1:0] rem_idx;
    logic [31:0]   gone;
    logic [32:0]   fold_sum;
    logic [31:0]   fold;

    assign pos_idx    = r_pos[IW-1:0];
    assign walk_delta = r_delta[pos_idx];
    assign walk_more  = (r_pos < r_count) && (r_ins_d > walk_delta);
    assign rem_idx    = i_cmd.rem_head ? '0 : CW'(r_slot);
    assign gone       = r_delta[rem_idx[IW-1:0]];

    always_comb begin
        fold_sum = 33'd0;
        if (rem_idx + CW'(1) < r_count)
            fold_sum = {1'b0, r_delta[rem_idx[IW-1:0] + IW'(1)]} + {1'b0, gone};
        fold = fold_sum[32] ? 32'hFFFF_FFFF : fold_sum[31:0];
    end

    assign o_sts.full          = (r_count == CW'(S));
    assign o_sts.empty         = (r_count == '0);
    assign o_sts.head_zero     = (r_delta[0] == 32'd0);
    assign o_sts.bad_slot      = (CW'(r_slot) >= r_count);
    assign o_sts.walk_done     = !walk_more;
    assign o_sts.head_periodic = (r_period[0] != 32'd0);
    assign o_sts.head_handle   = r_handle[0];
    assign o_sts.count         = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < S; k++) begin
                r_delta[k]  <= '0;
                r_period[k] <= '0;
                r_handle[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_slot <= i_slot;
            end
            if (i_cmd.ins_init) begin
                r_pos <= '0;
                if (i_cmd.use_head) begin
                    r_ins_d <= r_hd_p;
                    r_ins_p <= r_hd_p;
                    r_ins_h <= r_hd_h;
                end else begin
                    r_ins_d <= i_start_delay;
                    r_ins_p <= i_repeat_period;
                    r_ins_h <= i_task_handle;
                end
            end
            if (i_cmd.ins_step && walk_more) begin
                r_ins_d <= r_ins_d - walk_delta;
                r_pos   <= r_pos + CW'(1);
            end
            if (i_cmd.tick && r_count != '0 && r_delta[0] != 32'd0) begin
                r_delta[0] <= r_delta[0] - 32'd1;
            end
            if (i_cmd.ins_write) begin
                for (int k = 1; k < S; k++) begin
                    if (CW'(k) > r_pos && CW'(k) <= r_count) begin
                        r_delta[k]  <= r_delta[k-1];
                        r_period[k] <= r_period[k-1];
                        r_handle[k] <= r_handle[k-1];
                    end
                end
                r_delta[pos_idx]  <= r_ins_d;
                r_period[pos_idx] <= r_ins_p;
                r_handle[pos_idx] <= r_ins_h;
                if (r_pos < r_count)
                    r_delta[pos_idx + IW'(1)] <= walk_delta - r_ins_d;
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.rem_write) begin
                if (i_cmd.rem_head) begin
                    r_hd_p <= r_period[0];
                    r_hd_h <= r_handle[0];
                end
                for (int k = 0; k < S - 1; k++) begin
                    if (CW'(k) >= rem_idx && CW'(k + 1) < r_count) begin
                        r_delta[k]  <= r_delta[k+1];
                        r_period[k] <= r_period[k+1];
                        r_handle[k] <= r_handle[k+1];
                    end
                end
                if (rem_idx + CW'(1) < r_count)
                    r_delta[rem_idx[IW-1:0]] <= fold;
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule

FILE: design/dlts_ctrl.sv
// Controller of the delta-list timer queue: sequences walks, shifts and the
// dispatch loop, and drives the result strobe. Uses dlts_pkg.
module dlts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  dlts_pkg::t_dp_sts i_sts,
    output dlts_pkg::t_dp_cmd o_cmd,
    output logic              o_valid,
    output logic [7:0]        o_run_handle,
    output logic [2:0]        o_status,
    output logic [4:0]        o_entry_count,
    output logic              o_is_last
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_WALK, S_INS, S_POP_CHECK, S_POP_REINS, S_POP_WALK, S_POP_INS
    } t_state;

    localparam int CW = dlts_pkg::CntW;
    localparam int PW = $clog2(dlts_pkg::MaxPops + 1);

    t_state r_state;
    logic [1:0] r_func;
    logic [PW-1:0] r_pops;
    logic [7:0] r_ran_h;
    logic r_valid, r_last;
    logic [7:0] r_rh;
    logic [2:0] r_st;
    logic [4:0] r_cnt;
    logic r_last_out;
    logic r_pend;   // result whose count is sampled next cycle
    logic r_post;   // result carries the popped task handle

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_run_handle = r_rh;
    assign o_status = r_st;
    assign o_is_last = r_last_out;
    assign o_entry_count = r_cnt;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                o_cmd.ins_init = start;
            end
            S_DECODE: begin
                o_cmd.tick = (r_func == dlts_pkg::FUNC_TICK);
                o_cmd.rem_write = (r_func == dlts_pkg::FUNC_DELETE) && !i_sts.bad_slot;
            end
            S_WALK:      o_cmd.ins_step = 1'b1;
            S_INS:       o_cmd.ins_write = 1'b1;
            S_POP_CHECK: begin
                o_cmd.rem_head = 1'b1;
                o_cmd.rem_write = (r_pops != PW'(dlts_pkg::MaxPops))
                                  && !i_sts.empty && i_sts.head_zero;
            end
            S_POP_REINS: begin
                o_cmd.ins_init = 1'b1;
                o_cmd.use_head = 1'b1;
            end
            S_POP_WALK:  o_cmd.ins_step = 1'b1;
            S_POP_INS:   o_cmd.ins_write = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_last     <= 1'b0;
            r_func     <= '0;
            r_pops     <= '0;
            r_rh       <= '0;
            r_st       <= '0;
            r_cnt      <= '0;
            r_last_out <= 1'b0;
            r_ran_h    <= '0;
            r_pend     <= 1'b0;
            r_post     <= 1'b0;
        end else begin
            // a result is raised through r_pend and r_valid after its count update lands;
            // hold the count of that moment, a further pop may follow at once
            r_valid <= r_pend;
            r_pend  <= 1'b0;
            if (r_pend) begin
                r_rh       <= r_post ? r_ran_h : 8'd0;
                r_cnt      <= 5'(i_sts.count);
                r_last_out <= r_last;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_last <= 1'b0;
                    if (start) begin
                        r_func  <= i_func;
                        r_pops  <= '0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    unique case (r_func)
                        dlts_pkg::FUNC_ADD: begin
                            if (i_sts.full) begin
                                r_st <= dlts_pkg::ST_FULL; r_post <= 1'b0;
                                r_pend <= 1'b1; r_last <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                        dlts_pkg::FUNC_TICK: begin
                            r_st <= dlts_pkg::ST_OK; r_post <= 1'b0;
                            r_pend <= 1'b1; r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        dlts_pkg::FUNC_DISPATCH: r_state <= S_POP_CHECK;
                        default: begin
                            r_st <= i_sts.bad_slot ? dlts_pkg::ST_BADSLOT : dlts_pkg::ST_OK;
                            r_post <= 1'b0;
                            r_pend <= 1'b1; r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_WALK: if (i_sts.walk_done) r_state <= S_INS;
                S_INS: begin
                    r_st <= dlts_pkg::ST_OK; r_post <= 1'b0;
                    r_pend <= 1'b1; r_last <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_POP_CHECK: begin
                    if (o_cmd.rem_write) begin
                        r_ran_h <= i_sts.head_handle;
                        r_pops  <= r_pops + PW'(1);
                        r_state <= i_sts.head_periodic ? S_POP_REINS : S_POP_CHECK;
                        if (!i_sts.head_periodic) begin
                            r_st <= dlts_pkg::ST_RAN; r_post <= 1'b1; r_pend <= 1'b1;
                        end
                    end else if (!r_pend && !r_valid) begin
                        r_st <= dlts_pkg::ST_DONE; r_post <= 1'b0;
                        r_pend <= 1'b1; r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_POP_REINS: r_state <= S_POP_WALK;
                S_POP_WALK:  if (i_sts.walk_done) r_state <= S_POP_INS;
                S_POP_INS: begin
                    r_st <= dlts_pkg::ST_RAN; r_post <= 1'b1; r_pend <= 1'b1;
                    r_state <= S_POP_CHECK;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/delta_list_task_scheduler.sv
// Delta-list timer queue.
// Command channel: an input word is taken on a rising edge with start high
// and busy low; busy drops once the last result is scheduled, and that word
// appears after busy drops, through the r_pend and r_valid registers.
// Operations: add (insert sorted by due time), tick (count the head down),
// dispatch (pop up to 16 due head entries, re-adding periodic ones) and delete.
// Result channel: o_valid marks each result word for exactly one cycle;
// the receiver cannot stall, so results are simply presented.
// o_is_last marks the final result of a command; a dispatch gives one
// "task ran" word per popped entry and then one "dispatch done" word.
// Add walks the stored deltas to its insert position, one entry per cycle
// (positions up to 15); dispatch pops one-shot entries directly and re-adds
// each periodic entry by the same walk, then gives the done word once the
// last "task ran" word has been presented.
// The walk over stored deltas in the datapath sets the throughput.
// Reset (synchronous, active low) empties the list and clears all entries.
// Files: uses dlts_pkg, dlts_ctrl and dlts_datapath.
module delta_list_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_task_handle,
    input  logic [31:0] i_start_delay,
    input  logic [31:0] i_repeat_period,
    input  logic [3:0]  i_slot,
    output logic        o_valid,
    output logic [7:0]  o_run_handle,
    output logic [2:0]  o_status,
    output logic [4:0]  o_entry_count,
    output logic        o_is_last
);
    dlts_pkg::t_dp_cmd cmd;
    dlts_pkg::t_dp_sts sts;

    dlts_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy, .i_func,
        .i_sts(sts), .o_cmd(cmd),
        .o_valid, .o_run_handle, .o_status, .o_entry_count, .o_is_last
    );

    dlts_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_task_handle, .i_start_delay, .i_repeat_period, .i_slot,
        .o_sts(sts)
    );
endmodule

FILE: design/dlts_checker.sv
// Port-level checks for the delta-list timer queue, bound to the top level.
// Depends on dlts_pkg and the top-level ports.
module dlts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic [4:0] o_entry_count,
    input logic       o_is_last
);
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= 5'd16) else $error("count out of range");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dlts_pkg::ST_DONE) |-> o_is_last)
        else $error("done not last");
    a_ran_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dlts_pkg::ST_RAN) |-> !o_is_last)
        else $error("ran marked last");
endmodule

bind delta_list_task_scheduler dlts_checker u_dlts_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_status, .o_entry_count, .o_is_last
);
